// ===== sv/zebra_stripe_run_detector_top_macros.svh =====
// ----------------------------------------------------------------------------
// Zebra stripe run detector: assertion macros
// Shared concurrent assertion forms. They compile away when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef ZEBRA_STRIPE_RUN_DETECTOR_TOP_MACROS_SVH
`define ZEBRA_STRIPE_RUN_DETECTOR_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// The consequent must hold in the same cycle as the antecedent.
`define ZSRD_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define ZSRD_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ZSRD_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons, msg)
`define ZSRD_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg)
`endif

`endif

// ===== sv/zsrd_pkg.sv =====
// ----------------------------------------------------------------------------
// Zebra stripe run detector package
// Field widths, function and register codes, reset values and shared types.
// ----------------------------------------------------------------------------
package zsrd_pkg;

  // Field widths.
  localparam int FUNC_W    = 2;
  localparam int PIX_W     = 8;
  localparam int THR_W     = 8;
  localparam int LEN_W     = 6;
  localparam int PASS_W    = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 8;

  // Only the low PIXEL_BITS bits of a pixel are significant.
  localparam int PIXEL_BITS = 8;
  localparam logic [PIX_W-1:0] PIX_MASK =
    PIX_W'((PIXEL_BITS >= PIX_W) ? {PIX_W{1'b1}} : ((1 << PIXEL_BITS) - 1));

  // Function codes of an input beat.
  localparam logic [FUNC_W-1:0] FUNC_CENTRE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LEFT   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RIGHT  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_MIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_MAX     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIFF_MAX    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_STRIPES = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [THR_W-1:0]  RST_THRESHOLD   = 8'd128;
  localparam logic [LEN_W-1:0]  RST_RUN_MIN     = 6'd2;
  localparam logic [LEN_W-1:0]  RST_RUN_MAX     = 6'd20;
  localparam logic [LEN_W-1:0]  RST_DIFF_MAX    = 6'd10;
  localparam logic [PASS_W-1:0] RST_MIN_STRIPES = 4'd6;

  // Saturation points of the run tracker.
  localparam logic [LEN_W-1:0]  LEN_SAT   = {LEN_W{1'b1}};
  localparam logic [PASS_W-1:0] PASS_SAT  = {PASS_W{1'b1}};
  localparam logic [LEN_W-1:0]  IDX_WRAP  = LEN_SAT - 6'd1;
  localparam logic [LEN_W-1:0]  IDX_CHECK = 6'd2;

  typedef struct packed {
    logic [THR_W-1:0]  threshold;
    logic [LEN_W-1:0]  run_min;
    logic [LEN_W-1:0]  run_max;
    logic [LEN_W-1:0]  diff_max;
    logic [PASS_W-1:0] min_stripes;
  } cfg_t;

  // Per-side control for one processed beat.
  typedef struct packed {
    logic clear;
    logic step;
    logic px_dark;
    logic start_dark;
  } side_ctl_t;

endpackage

// ===== sv/zsrd_in_if.sv =====
// ----------------------------------------------------------------------------
// Pixel input channel
// Valid/ready channel carrying one pixel beat.
// ----------------------------------------------------------------------------
interface zsrd_in_if;
  import zsrd_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [PIX_W-1:0]  pixel;
  logic              last;

  modport source (output valid, func, pixel, last, input ready);
  modport sink   (input valid, func, pixel, last, output ready);
endinterface

// ===== sv/zsrd_out_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the zebra flags of one scan.
// ----------------------------------------------------------------------------
interface zsrd_out_if;
  logic valid;
  logic ready;
  logic left_zebra;
  logic right_zebra;
  logic both_zebra;

  modport source (output valid, left_zebra, right_zebra, both_zebra, input ready);
  modport sink   (input valid, left_zebra, right_zebra, both_zebra, output ready);
endinterface

// ===== sv/zsrd_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface zsrd_cfg_if;
  import zsrd_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/zebra_stripe_run_detector_top.sv =====
// A pixel beat marked last is registered in the input stage, then its flags in the result register.
// The input stage takes one pixel beat per cycle while no last beat waits in it.
// A last beat waits in the input stage only while the result register is full and not being read.
// Reset: synchronous, active low; clears the scans, the channels' valid
// flags and restores the configuration defaults.
// ----------------------------------------------------------------------------
// Zebra stripe run detector
// Input stage, two side run trackers and a result register.
// ----------------------------------------------------------------------------
module zebra_stripe_run_detector_top (
  input  logic        clk,
  input  logic        rst_n,
  zsrd_in_if.sink     in_if,
  zsrd_out_if.source  out_if,
  zsrd_cfg_if.sink    cfg_if
);
  import zsrd_pkg::*;

`include "zebra_stripe_run_detector_top_macros.svh"

  cfg_t              cfg;
  logic              s_valid_r;
  logic [FUNC_W-1:0] s_func_r;
  logic [PIX_W-1:0]  s_pix_r;
  logic              s_last_r;
  logic              s_go;
  logic              in_acc;
  logic              start_dark_r, start_dark_nxt;
  logic              out_valid_r;
  logic              left_r, right_r, both_r;
  logic              lz, rz;
  logic              px_side;
  logic              px_dark;
  side_ctl_t         left_ctl, right_ctl;
  logic [PASS_W-1:0] left_pass_nxt, right_pass_nxt;

  zsrd_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  // Handshake: the stage moves on unless a last beat meets a full result slot.
  assign s_go        = s_valid_r && (!s_last_r || !out_valid_r || out_if.ready);
  assign in_if.ready = !s_valid_r || s_go;
  assign in_acc      = in_if.valid && in_if.ready;

  // Input stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_acc) begin
      s_valid_r <= 1'b1;
    end else if (s_go) begin
      s_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s_func_r <= in_if.func;
      s_pix_r  <= in_if.pixel & PIX_MASK;
      s_last_r <= in_if.last;
    end
  end

  // Pixel classification and side steering.
  assign px_side = s_pix_r != cfg.threshold;
  assign px_dark = s_pix_r < cfg.threshold;

  always_comb begin
    start_dark_nxt = start_dark_r;
    if (s_go && (s_func_r == FUNC_CENTRE)) begin
      start_dark_nxt = s_pix_r > cfg.threshold;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_dark_r <= 1'b0;
    end else begin
      start_dark_r <= start_dark_nxt;
    end
  end

  always_comb begin
    left_ctl.clear       = s_go && (s_func_r == FUNC_CENTRE);
    left_ctl.step        = s_go && (s_func_r == FUNC_LEFT) && px_side;
    left_ctl.px_dark     = px_dark;
    left_ctl.start_dark  = start_dark_r;
    right_ctl.clear      = left_ctl.clear;
    right_ctl.step       = s_go && (s_func_r == FUNC_RIGHT) && px_side;
    right_ctl.px_dark    = px_dark;
    right_ctl.start_dark = start_dark_r;
  end

  zsrd_side u_left (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (left_ctl),
    .cfg      (cfg),
    .pass_nxt (left_pass_nxt)
  );

  zsrd_side u_right (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (right_ctl),
    .cfg      (cfg),
    .pass_nxt (right_pass_nxt)
  );

  // Result register, loaded from the counts after this beat's update.
  assign lz = left_pass_nxt >= cfg.min_stripes;
  assign rz = right_pass_nxt >= cfg.min_stripes;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s_go && s_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_go && s_last_r) begin
      left_r  <= lz;
      right_r <= rz;
      both_r  <= lz && rz;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.left_zebra  = left_r;
  assign out_if.right_zebra = right_r;
  assign out_if.both_zebra  = both_r;

  // A last beat must never pass a result that is still waiting.
  `ZSRD_ASSERT_SAME(a_no_overrun, clk, rst_n, s_valid_r && s_last_r && out_valid_r && !out_if.ready, !s_go, "last beat overran a waiting result")
  // A processed last beat always shows up as a result next cycle.
  `ZSRD_ASSERT_NEXT(a_result_loaded, clk, rst_n, s_go && s_last_r, out_valid_r, "processed last beat produced no result")
  // The crossing flag is the AND of the side flags.
  `ZSRD_ASSERT_SAME(a_both_and, clk, rst_n, out_valid_r, both_r == (left_r && right_r), "crossing flag disagrees with side flags")

endmodule

// ===== sv/zsrd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the detector settings; every write beat is taken at once.
// ----------------------------------------------------------------------------
module zsrd_cfg_regs (
  input  logic           clk,
  input  logic           rst_n,
  zsrd_cfg_if.sink       cfg_if,
  output zsrd_pkg::cfg_t cfg
);
  import zsrd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_if.ready = 1'b1;
  assign cfg         = cfg_r;

  // Register decode; unknown indexes are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_THRESHOLD:   cfg_nxt.threshold   = cfg_if.data[THR_W-1:0];
        REG_RUN_MIN:     cfg_nxt.run_min     = cfg_if.data[LEN_W-1:0];
        REG_RUN_MAX:     cfg_nxt.run_max     = cfg_if.data[LEN_W-1:0];
        REG_DIFF_MAX:    cfg_nxt.diff_max    = cfg_if.data[LEN_W-1:0];
        REG_MIN_STRIPES: cfg_nxt.min_stripes = cfg_if.data[PASS_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold   <= RST_THRESHOLD;
      cfg_r.run_min     <= RST_RUN_MIN;
      cfg_r.run_max     <= RST_RUN_MAX;
      cfg_r.diff_max    <= RST_DIFF_MAX;
      cfg_r.min_stripes <= RST_MIN_STRIPES;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== sv/zsrd_side.sv =====
// ----------------------------------------------------------------------------
// Side run tracker
// Splits one side of the row into light and dark runs and counts the
// leading runs that pass the length and neighbour checks.
// ----------------------------------------------------------------------------
module zsrd_side (
  input  logic                          clk,
  input  logic                          rst_n,
  input  zsrd_pkg::side_ctl_t           ctl,
  input  zsrd_pkg::cfg_t                cfg,
  output logic [zsrd_pkg::PASS_W-1:0]   pass_nxt
);
  import zsrd_pkg::*;

  logic [LEN_W-1:0]  idx_r, idx_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-1:0]  prev_r, prev_nxt;
  logic [PASS_W-1:0] pass_r;
  logic              brk_r, brk_nxt;
  logic              cur_dark;
  logic [LEN_W-1:0]  diff;
  logic              fail;
  logic              check;

  // Colour of the open run alternates with the run index.
  assign cur_dark = ctl.start_dark ^ idx_r[0];
  assign diff     = (prev_r > len_r) ? (prev_r - len_r) : (len_r - prev_r);
  assign fail     = (prev_r < cfg.run_min) || (prev_r >= cfg.run_max) ||
                    (diff >= cfg.diff_max);
  assign check    = (idx_r >= IDX_CHECK) && !brk_r;

  // Next state: extend the open run, or close it and check the one before.
  always_comb begin
    idx_nxt  = idx_r;
    len_nxt  = len_r;
    prev_nxt = prev_r;
    pass_nxt = pass_r;
    brk_nxt  = brk_r;
    if (ctl.clear) begin
      idx_nxt  = '0;
      len_nxt  = '0;
      prev_nxt = '0;
      pass_nxt = '0;
      brk_nxt  = 1'b0;
    end else if (ctl.step) begin
      if (ctl.px_dark == cur_dark) begin
        if (len_r != LEN_SAT) begin
          len_nxt = len_r + 6'd1;
        end
      end else begin
        if (check) begin
          if (fail) begin
            brk_nxt = 1'b1;
          end else if (pass_r != PASS_SAT) begin
            pass_nxt = pass_r + 4'd1;
          end
        end
        prev_nxt = len_r;
        len_nxt  = 6'd1;
        // Past the top the index toggles so the colour parity holds.
        if (idx_r >= IDX_WRAP) begin
          idx_nxt = idx_r ^ 6'd1;
        end else begin
          idx_nxt = idx_r + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      len_r  <= '0;
      prev_r <= '0;
      pass_r <= '0;
      brk_r  <= 1'b0;
    end else begin
      idx_r  <= idx_nxt;
      len_r  <= len_nxt;
      prev_r <= prev_nxt;
      pass_r <= pass_nxt;
      brk_r  <= brk_nxt;
    end
  end

endmodule

// ===== dv/zebra_stripe_run_detector_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zebra stripe run detector testbench
// Drives pixel scans into the detector with random gaps and output stalls.
// It predicts the zebra flags of every scan and compares each result beat with
// them. The run covers several register settings, their extremes among them.
// ----------------------------------------------------------------------------
module zebra_stripe_run_detector_top_tb;
  import zsrd_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASE_COUNT   = 10;
  localparam int PHASE_ITEMS   = 100;

  // Function code that the block does not use; its pixel is ignored.
  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

  typedef struct packed {
    logic [LEN_W-1:0]  run_index;
    logic [LEN_W-1:0]  run_len;
    logic [LEN_W-1:0]  prev_len;
    logic [PASS_W-1:0] pass_count;
    logic              broken;
  } side_track_t;

  typedef struct packed {
    logic left_zebra;
    logic right_zebra;
    logic both_zebra;
  } zebra_flags_t;

  // Tracks both side scans and holds the zebra flags still owed by the block.
  class stripe_flag_tracker;
    cfg_t         regs;
    logic         start_dark;
    side_track_t  left_side;
    side_track_t  right_side;
    zebra_flags_t pending_flags[$];
    int           fails;

    function new();
      regs.threshold   = RST_THRESHOLD;
      regs.run_min     = RST_RUN_MIN;
      regs.run_max     = RST_RUN_MAX;
      regs.diff_max    = RST_DIFF_MAX;
      regs.min_stripes = RST_MIN_STRIPES;
      start_dark       = 1'b0;
      clear_sides();
      fails            = 0;
    endfunction

    function void clear_sides();
      left_side  = '0;
      right_side = '0;
    endfunction

    // Register writes keep only the bits that each register holds.
    function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DAT_W-1:0] data);
      case (index)
        REG_THRESHOLD:   regs.threshold   = data;
        REG_RUN_MIN:     regs.run_min     = data[LEN_W-1:0];
        REG_RUN_MAX:     regs.run_max     = data[LEN_W-1:0];
        REG_DIFF_MAX:    regs.diff_max    = data[LEN_W-1:0];
        REG_MIN_STRIPES: regs.min_stripes = data[PASS_W-1:0];
        default: ;
      endcase
    endfunction

    // One coloured pixel on one side: extend the open run, or close it and
    // judge the run before it against its length limits and its neighbour.
    function side_track_t advance_side(side_track_t s, logic px_dark);
      logic             run_dark;
      logic [LEN_W-1:0] gap;
      run_dark = start_dark ^ s.run_index[0];
      if (px_dark == run_dark) begin
        if (s.run_len != LEN_SAT) s.run_len = s.run_len + 1'b1;
        return s;
      end
      if (s.run_index >= IDX_CHECK && !s.broken) begin
        gap = (s.prev_len > s.run_len) ? s.prev_len - s.run_len : s.run_len - s.prev_len;
        if (s.prev_len < regs.run_min || s.prev_len >= regs.run_max ||
            gap >= regs.diff_max) begin
          s.broken = 1'b1;
        end else if (s.pass_count != PASS_SAT) begin
          s.pass_count = s.pass_count + 1'b1;
        end
      end
      s.prev_len = s.run_len;
      s.run_len  = 6'd1;
      // Past the top the index toggles its low bit so the colour stays right.
      if (s.run_index >= IDX_WRAP) s.run_index[0] = ~s.run_index[0];
      else s.run_index = s.run_index + 1'b1;
      return s;
    endfunction

    // Called for every accepted pixel beat.
    function void note_pixel(logic [FUNC_W-1:0] func, logic [PIX_W-1:0] pixel, logic last);
      logic [PIX_W-1:0] px;
      zebra_flags_t     flags;
      px = pixel & PIX_MASK;
      case (func)
        FUNC_CENTRE: begin
          start_dark = (px > regs.threshold);
          clear_sides();
        end
        FUNC_LEFT: begin
          if (px != regs.threshold) left_side = advance_side(left_side, px < regs.threshold);
        end
        FUNC_RIGHT: begin
          if (px != regs.threshold) right_side = advance_side(right_side, px < regs.threshold);
        end
        default: ;
      endcase
      if (last) begin
        flags.left_zebra  = (left_side.pass_count >= regs.min_stripes);
        flags.right_zebra = (right_side.pass_count >= regs.min_stripes);
        flags.both_zebra  = flags.left_zebra & flags.right_zebra;
        pending_flags.push_back(flags);
      end
    endfunction

    // Called for every accepted result beat.
    function void check_flags(logic left_zebra, logic right_zebra, logic both_zebra);
      zebra_flags_t flags;
      if (pending_flags.size() == 0) begin
        $error("result beat arrived with no scan result pending");
        fails++;
        return;
      end
      flags = pending_flags.pop_front();
      if (left_zebra !== flags.left_zebra) begin
        $error("left_zebra mismatch: expected %0b, actual %0b", flags.left_zebra, left_zebra);
        fails++;
      end
      if (right_zebra !== flags.right_zebra) begin
        $error("right_zebra mismatch: expected %0b, actual %0b", flags.right_zebra, right_zebra);
        fails++;
      end
      if (both_zebra !== flags.both_zebra) begin
        $error("both_zebra mismatch: expected %0b, actual %0b", flags.both_zebra, both_zebra);
        fails++;
      end
    endfunction

    function int pending();
      return pending_flags.size();
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  int   src_calm;
  int   sink_calm;
  int   items_sent;
  int   cycle_count;

  logic [PIX_W-1:0] left_px[$];
  logic [PIX_W-1:0] right_px[$];

  stripe_flag_tracker tracker;

  zsrd_in_if  in_bus ();
  zsrd_out_if out_bus ();
  zsrd_cfg_if cfg_bus ();

  zebra_stripe_run_detector_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_bus),
    .out_if (out_bus),
    .cfg_if (cfg_bus)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Idle cycles before a beat; now and then a calm stretch with no idling.
  function automatic int idle_cycles(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(29, 0) == 0) begin
      calm_left = $urandom_range(40, 8);
      return 0;
    end
    return $urandom_range(17, 0);
  endfunction

  // A pixel of the wanted colour; at a threshold extreme it falls back to
  // the threshold itself, which the block ignores.
  function automatic logic [PIX_W-1:0] shade(bit want_dark, logic [PIX_W-1:0] th);
    if (want_dark) return (th == '0) ? th : PIX_W'($urandom_range(int'(th) - 1, 0));
    return (th == '1) ? th : PIX_W'($urandom_range(255, int'(th) + 1));
  endfunction

  task automatic send_pixel(logic [FUNC_W-1:0] func, logic [PIX_W-1:0] pixel, logic last);
    int gap;
    gap = idle_cycles(src_calm);
    if (gap > 0) begin
      @(negedge clk);
      in_bus.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_bus.valid = 1'b1;
    in_bus.func  = func;
    in_bus.pixel = pixel;
    in_bus.last  = last;
    forever begin
      @(posedge clk);
      if (in_bus.ready) break;
    end
    tracker.note_pixel(func, pixel, last);
    items_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DAT_W-1:0] data);
    @(negedge clk);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = index;
    cfg_bus.data  = data;
    forever begin
      @(posedge clk);
      if (cfg_bus.ready) break;
    end
    tracker.write_reg(index, data);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  // Hold the pixel channel until every owed result beat has come back.
  task automatic drain_results();
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // One register setting per phase; unused upper data bits are randomised.
  task automatic configure(int phase);
    logic [THR_W-1:0]  th;
    logic [LEN_W-1:0]  rmin;
    logic [LEN_W-1:0]  rmax;
    logic [LEN_W-1:0]  dmax;
    logic [PASS_W-1:0] need;
    th   = THR_W'($urandom_range(220, 40));
    rmin = LEN_W'($urandom_range(5, 1));
    rmax = rmin + LEN_W'($urandom_range(18, 2));
    dmax = LEN_W'($urandom_range(12, 1));
    need = PASS_W'($urandom_range(10, 1));
    case (phase)
      0: begin
        th = RST_THRESHOLD; rmin = RST_RUN_MIN; rmax = RST_RUN_MAX;
        dmax = RST_DIFF_MAX; need = RST_MIN_STRIPES;
      end
      1: th = '0;
      2: th = '1;
      3: begin rmin = '0; rmax = LEN_SAT; dmax = LEN_SAT; need = PASS_SAT; end
      4: begin rmin = LEN_SAT; rmax = 6'd1; dmax = 6'd1; need = 4'd1; end
      5: need = '0;
      default: ;
    endcase
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_THRESHOLD, th);
    write_reg(REG_RUN_MIN, {2'($urandom), rmin});
    write_reg(REG_RUN_MAX, {2'($urandom), rmax});
    write_reg(REG_DIFF_MAX, {2'($urandom), dmax});
    write_reg(REG_MIN_STRIPES, {4'($urandom), need});
    // A write to an index past the last register must change nothing.
    if (phase == 7) write_reg(REG_MIN_STRIPES + CFG_IDX_W'($urandom_range(3, 1)), 8'($urandom));
  endtask

  // Builds one side of a scan: an optional short run 0, then alternating runs.
  task automatic make_side(bit to_right, bit run0_dark, int nruns, int width, int jitter,
                           int flip_odds);
    logic [PIX_W-1:0] q[$];
    logic [PIX_W-1:0] th;
    bit               dark;
    int               len;
    th   = tracker.regs.threshold;
    dark = run0_dark;
    for (int r = 0; r <= nruns; r++) begin
      if (r == 0) begin
        len = $urandom_range(2, 0);
      end else begin
        len = width + $urandom_range(2 * jitter, 0) - jitter;
        if (len < 1) len = 1;
      end
      repeat (len) begin
        if ($urandom_range(24, 0) == 0) q.push_back(th);
        if (flip_odds != 0 && $urandom_range(flip_odds - 1, 0) == 0) q.push_back(shade(!dark, th));
        else q.push_back(shade(dark, th));
      end
      dark = !dark;
    end
    if (to_right) right_px = q;
    else left_px = q;
  endtask

  // One scan: mostly a centre pixel and striped sides, sometimes pure noise,
  // very long runs, very many runs or enough runs to saturate the count.
  task automatic run_scan();
    logic [PIX_W-1:0] th;
    logic [PIX_W-1:0] centre_px;
    logic [PIX_W-1:0] px;
    int               kind;
    int               n;
    int               lo;
    int               hi;
    int               width;
    int               nruns;
    int               jitter;
    int               flips;
    bit               use_right;
    bit               scan_done;
    th   = tracker.regs.threshold;
    kind = $urandom_range(99, 0);
    if (kind < 10) begin
      n = $urandom_range(30, 8);
      for (int k = 0; k < n; k++) begin
        send_pixel(FUNC_W'($urandom), PIX_W'($urandom),
                   (k == n - 1) || ($urandom_range(7, 0) == 0));
      end
      return;
    end
    centre_px = ($urandom_range(19, 0) == 0) ? th : shade($urandom_range(1, 0), th);
    lo = (tracker.regs.run_min == '0) ? 1 : int'(tracker.regs.run_min);
    hi = (int'(tracker.regs.run_max) > lo) ? int'(tracker.regs.run_max) - 1 : lo;
    if (hi > lo + 4 && $urandom_range(3, 0) != 0) hi = lo + 4;
    width = $urandom_range(hi, lo);
    nruns = $urandom_range(1, 0) ? int'(tracker.regs.min_stripes) + 2 + $urandom_range(2, 0)
                                 : $urandom_range(18, 1);
    if (width > 20) nruns = $urandom_range(4, 1);
    jitter = ($urandom_range(3, 0) == 0) ? $urandom_range(int'(tracker.regs.diff_max) + 1, 0)
                                         : $urandom_range(1, 0);
    flips  = ($urandom_range(4, 0) == 0) ? 40 : 0;
    if (kind < 13) begin
      width = 70; nruns = 2;
    end else if (kind < 16) begin
      width = 1; nruns = 75; jitter = 0;
    end else if (kind < 20) begin
      nruns = 20; jitter = 0; flips = 0;
    end
    send_pixel(FUNC_CENTRE, centre_px, 1'b0);
    make_side(1'b0, centre_px > th, nruns, width, jitter, flips);
    make_side(1'b1, centre_px > th, nruns, width, jitter, flips);
    // Interleave the two sides at random; the final beat asks for the result.
    while (left_px.size() + right_px.size() > 0) begin
      use_right = (left_px.size() == 0) || (right_px.size() != 0 && $urandom_range(1, 0) == 1);
      px        = use_right ? right_px.pop_front() : left_px.pop_front();
      scan_done = (left_px.size() + right_px.size() == 0);
      if ($urandom_range(59, 0) == 0) send_pixel(FUNC_SPARE, PIX_W'($urandom), 1'b0);
      send_pixel(use_right ? FUNC_RIGHT : FUNC_LEFT, px,
                 scan_done || ($urandom_range(39, 0) == 0));
    end
  endtask

  // Result side: stall for a random time, then take and check one beat.
  initial begin
    int stall;
    out_bus.ready = 1'b0;
    sink_calm     = 0;
    wait (rst_n === 1'b1);
    forever begin
      stall = idle_cycles(sink_calm);
      if (stall > 0) begin
        @(negedge clk);
        out_bus.ready = 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_bus.ready = 1'b1;
      forever begin
        @(posedge clk);
        if (out_bus.valid) break;
      end
      tracker.check_flags(out_bus.left_zebra, out_bus.right_zebra, out_bus.both_zebra);
    end
  end

  // Watchdog on the whole run.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Main sequence: reset, directed corner beats, then the register phases.
  initial begin
    int phase_start;
    in_bus.valid  = 1'b0;
    in_bus.func   = FUNC_CENTRE;
    in_bus.pixel  = '0;
    in_bus.last   = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = REG_THRESHOLD;
    cfg_bus.data  = '0;
    src_calm      = 0;
    items_sent    = 0;
    tracker       = new();
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Centre with a result request, an empty run 0, ignored pixels and the
    // spare function code, all under the reset register values.
    send_pixel(FUNC_CENTRE, 8'hFF, 1'b1);
    send_pixel(FUNC_LEFT, 8'h00, 1'b0);
    send_pixel(FUNC_LEFT, RST_THRESHOLD, 1'b0);
    send_pixel(FUNC_RIGHT, 8'hFF, 1'b0);
    send_pixel(FUNC_RIGHT, 8'h00, 1'b0);
    send_pixel(FUNC_SPARE, 8'hAA, 1'b1);
    send_pixel(FUNC_CENTRE, RST_THRESHOLD, 1'b0);
    send_pixel(FUNC_LEFT, 8'h7F, 1'b0);
    send_pixel(FUNC_LEFT, 8'h81, 1'b0);
    send_pixel(FUNC_RIGHT, 8'h55, 1'b0);
    send_pixel(FUNC_RIGHT, 8'hAA, 1'b1);
    send_pixel(FUNC_SPARE, 8'h55, 1'b0);
    send_pixel(FUNC_LEFT, 8'hFF, 1'b1);
    send_pixel(FUNC_RIGHT, 8'h00, 1'b1);
    send_pixel(FUNC_CENTRE, 8'h00, 1'b1);

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      configure(phase);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        run_scan();
        if ($urandom_range(24, 0) == 0) drain_results();
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
